FILE: src/bqa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqa_pkg
// Shared types and constants of the broadcast quantized int8 add unit.
// ----------------------------------------------------------------------------
package bqa_pkg;

  localparam int NUM_DIMS  = 4;
  localparam int DIM_BITS  = 16;
  localparam int IDX_BITS  = 32;
  localparam int DIV_STEPS = IDX_BITS;
  localparam int DIM_CELLS = DIV_STEPS + 1;
  localparam int CHAIN_LEN = NUM_DIMS * DIM_CELLS;

  localparam int Q_SHIFT = 15;
  localparam logic [14:0] ROUND_HALF = 15'h4000;
  localparam logic signed [21:0] SAT_HI = 22'sd127;
  localparam logic signed [21:0] SAT_LO = -22'sd128;

  typedef enum logic [2:0] {
    REG_SHAPE_A = 3'd0,
    REG_SHAPE_B = 3'd1,
    REG_ZP_A    = 3'd2,
    REG_ZP_B    = 3'd3,
    REG_ZP_OUT  = 3'd4,
    REG_SCALE_A = 3'd5,
    REG_SCALE_B = 3'd6,
    REG_RELU    = 3'd7
  } bqa_reg_t;

  typedef struct packed {
    logic [63:0]        shape_a;
    logic [63:0]        shape_b;
    logic signed [7:0]  zp_a;
    logic signed [7:0]  zp_b;
    logic signed [7:0]  zp_out;
    logic [23:0]        scale_a;
    logic [23:0]        scale_b;
    logic               relu;
  } bqa_cfg_t;

  // one item in flight through the chain
  typedef struct packed {
    logic                vld;
    logic                func;
    logic                err;
    logic [IDX_BITS-1:0] x;
    logic [DIM_BITS-1:0] r;
    logic [IDX_BITS-1:0] ia;
    logic [IDX_BITS-1:0] ib;
    logic [IDX_BITS-1:0] sa;
    logic [IDX_BITS-1:0] sb;
    logic signed [7:0]   sum;
  } bqa_item_t;

endpackage

FILE: src/bqa_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqa_div_cell
// One restoring division step: shifts in one dividend bit, emits one
// quotient bit.
// ----------------------------------------------------------------------------
module bqa_div_cell import bqa_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic [DIM_BITS-1:0] divisor,
  input  bqa_item_t           item_in,
  output bqa_item_t           item_out
);

  bqa_item_t           item_r;
  bqa_item_t           item_nxt;
  logic [DIM_BITS:0]   trial;
  logic [DIM_BITS:0]   diff;
  logic                ge;

  always_comb begin
    trial    = {item_in.r, item_in.x[IDX_BITS-1]};
    ge       = (trial >= {1'b0, divisor});
    diff     = trial - {1'b0, divisor};
    item_nxt = item_in;
    item_nxt.r = ge ? diff[DIM_BITS-1:0] : trial[DIM_BITS-1:0];
    item_nxt.x = {item_in.x[IDX_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.vld <= 1'b0;
    end else if (en) begin
      item_r <= item_nxt;
    end
  end

  assign item_out = item_r;

endmodule

FILE: src/bqa_acc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqa_acc_cell
// Closes one dimension: adds digit times stride to each operand index whose
// dimension is not 1, and advances the strides.
// ----------------------------------------------------------------------------
module bqa_acc_cell import bqa_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic [DIM_BITS-1:0] dim_a,
  input  logic [DIM_BITS-1:0] dim_b,
  input  bqa_item_t           item_in,
  output bqa_item_t           item_out
);

  bqa_item_t             item_r;
  bqa_item_t             item_nxt;
  logic [IDX_BITS-1:0]   digit;
  logic [IDX_BITS-1:0]   da_w;
  logic [IDX_BITS-1:0]   db_w;

  always_comb begin
    digit    = IDX_BITS'(item_in.r);
    da_w     = IDX_BITS'(dim_a);
    db_w     = IDX_BITS'(dim_b);
    item_nxt = item_in;
    if (dim_a != DIM_BITS'(1)) begin
      item_nxt.ia = item_in.ia + IDX_BITS'(digit * item_in.sa);
    end
    if (dim_b != DIM_BITS'(1)) begin
      item_nxt.ib = item_in.ib + IDX_BITS'(digit * item_in.sb);
    end
    item_nxt.sa = IDX_BITS'(item_in.sa * da_w);
    item_nxt.sb = IDX_BITS'(item_in.sb * db_w);
    // remainder restarts for the next dimension, quotient carries on
    item_nxt.r  = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.vld <= 1'b0;
    end else if (en) begin
      item_r <= item_nxt;
    end
  end

  assign item_out = item_r;

endmodule

FILE: src/bqa_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqa_front
// Entry stages: shape check, Q15 scaling products, then rounding, relu and
// saturation of the quantized sum.
// ----------------------------------------------------------------------------
module bqa_front import bqa_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  logic                func,
  input  logic [IDX_BITS-1:0] flat_index,
  input  logic signed [7:0]   value_a,
  input  logic signed [7:0]   value_b,
  input  bqa_cfg_t            cfg,
  output bqa_item_t           item_out
);

  logic                 s1_vld_r;
  logic                 s1_func_r;
  logic                 s1_err_r;
  logic [IDX_BITS-1:0]  s1_x_r;
  logic signed [32:0]   s1_pa_r;
  logic signed [32:0]   s1_pb_r;
  logic signed [33:0]   s1_pc_r;

  logic                 err_nxt;
  logic signed [32:0]   pa_nxt;
  logic signed [32:0]   pb_nxt;
  logic signed [32:0]   pza;
  logic signed [32:0]   pzb;
  logic signed [33:0]   pc_nxt;

  logic signed [33:0]   ta;
  logic signed [33:0]   tb;
  logic signed [34:0]   tc;
  logic signed [21:0]   s;
  bqa_item_t            item_r;
  bqa_item_t            item_nxt;

  always_comb begin
    logic [DIM_BITS-1:0] da;
    logic [DIM_BITS-1:0] db;
    err_nxt = 1'b0;
    for (int k = 0; k < NUM_DIMS; k++) begin
      da = cfg.shape_a[16*k +: DIM_BITS];
      db = cfg.shape_b[16*k +: DIM_BITS];
      if (da == '0 || db == '0 ||
          !(da == db || da == DIM_BITS'(1) || db == DIM_BITS'(1))) begin
        err_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    pa_nxt = value_a * $signed({1'b0, cfg.scale_a});
    pb_nxt = value_b * $signed({1'b0, cfg.scale_b});
    pza    = cfg.zp_a * $signed({1'b0, cfg.scale_a});
    pzb    = cfg.zp_b * $signed({1'b0, cfg.scale_b});
    pc_nxt = {pza[32], pza} + {pzb[32], pzb};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r  <= in_vld;
      s1_func_r <= func;
      s1_err_r  <= err_nxt;
      s1_x_r    <= flat_index;
      s1_pa_r   <= pa_nxt;
      s1_pb_r   <= pb_nxt;
      s1_pc_r   <= pc_nxt;
    end
  end

  // floor shift by taking the upper bits of the two's complement value
  always_comb begin
    ta = {s1_pa_r[32], s1_pa_r} + $signed({19'd0, ROUND_HALF});
    tb = {s1_pb_r[32], s1_pb_r} + $signed({19'd0, ROUND_HALF});
    tc = {s1_pc_r[33], s1_pc_r} + $signed({20'd0, ROUND_HALF});
    s  = 22'($signed(ta[33:Q_SHIFT])) + 22'($signed(tb[33:Q_SHIFT]))
       - 22'($signed(tc[34:Q_SHIFT])) + 22'(cfg.zp_out);
    if (cfg.relu && s < 0) begin
      s = '0;
    end
    if (s > SAT_HI) begin
      s = SAT_HI;
    end
    if (s < SAT_LO) begin
      s = SAT_LO;
    end
    item_nxt      = '0;
    item_nxt.vld  = s1_vld_r;
    item_nxt.func = s1_func_r;
    item_nxt.err  = s1_err_r;
    item_nxt.x    = s1_x_r;
    item_nxt.sa   = IDX_BITS'(1);
    item_nxt.sb   = IDX_BITS'(1);
    item_nxt.sum  = s[7:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.vld <= 1'b0;
    end else if (en) begin
      item_r <= item_nxt;
    end
  end

  assign item_out = item_r;

endmodule

FILE: src/broadcast_quantized_int8_add_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// broadcast_quantized_int8_add_unit
// Quantized int8 add and broadcast operand index generator.
// ----------------------------------------------------------------------------
// pipeline: 2 entry stages, 32 division cells plus one accumulate cell per
//   dimension, output register
// throughput: one beat per cycle; the whole chain holds while the output
//   beat is stalled
// reset: synchronous active-low rst_n clears valid bits and loads register
//   defaults (unit shapes, zero points 0, scales 32768, relu off)
module broadcast_quantized_int8_add_unit import bqa_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_func,
  input  logic [31:0]         in_flat_index,
  input  logic signed [7:0]   in_value_a,
  input  logic signed [7:0]   in_value_b,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [31:0]         out_index_a,
  output logic [31:0]         out_index_b,
  output logic signed [7:0]   out_sum_value,
  output logic                out_shape_error,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_data
);

  bqa_cfg_t   cfg_r;
  logic       en;
  bqa_item_t  chain [CHAIN_LEN+1];
  bqa_item_t  last;

  logic                out_valid_r;
  logic [31:0]         out_index_a_r;
  logic [31:0]         out_index_b_r;
  logic signed [7:0]   out_sum_r;
  logic                out_err_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.shape_a <= 64'h0001_0001_0001_0001;
      cfg_r.shape_b <= 64'h0001_0001_0001_0001;
      cfg_r.zp_a    <= '0;
      cfg_r.zp_b    <= '0;
      cfg_r.zp_out  <= '0;
      cfg_r.scale_a <= 24'd32768;
      cfg_r.scale_b <= 24'd32768;
      cfg_r.relu    <= 1'b0;
    end else if (cfg_valid) begin
      unique case (bqa_reg_t'(cfg_index))
        REG_SHAPE_A: cfg_r.shape_a <= cfg_data;
        REG_SHAPE_B: cfg_r.shape_b <= cfg_data;
        REG_ZP_A:    cfg_r.zp_a    <= cfg_data[7:0];
        REG_ZP_B:    cfg_r.zp_b    <= cfg_data[7:0];
        REG_ZP_OUT:  cfg_r.zp_out  <= cfg_data[7:0];
        REG_SCALE_A: cfg_r.scale_a <= cfg_data[23:0];
        REG_SCALE_B: cfg_r.scale_b <= cfg_data[23:0];
        REG_RELU:    cfg_r.relu    <= cfg_data[0];
        default:     cfg_r.relu    <= cfg_r.relu;
      endcase
    end
  end

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  bqa_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_vld     (in_valid),
    .func       (in_func),
    .flat_index (in_flat_index),
    .value_a    (in_value_a),
    .value_b    (in_value_b),
    .cfg        (cfg_r),
    .item_out   (chain[0])
  );

  for (genvar k = 0; k < NUM_DIMS; k++) begin : g_dim
    logic [DIM_BITS-1:0] da;
    logic [DIM_BITS-1:0] db;
    logic [DIM_BITS-1:0] dout;

    assign da   = cfg_r.shape_a[16*k +: DIM_BITS];
    assign db   = cfg_r.shape_b[16*k +: DIM_BITS];
    assign dout = (da > db) ? da : db;

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
      bqa_div_cell u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .divisor  (dout),
        .item_in  (chain[k*DIM_CELLS + j]),
        .item_out (chain[k*DIM_CELLS + j + 1])
      );
    end

    bqa_acc_cell u_acc (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .dim_a    (da),
      .dim_b    (db),
      .item_in  (chain[k*DIM_CELLS + DIV_STEPS]),
      .item_out (chain[(k+1)*DIM_CELLS])
    );
  end

  assign last = chain[CHAIN_LEN];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= last.vld;
      if (last.func) begin
        out_index_a_r <= '0;
        out_index_b_r <= '0;
        out_sum_r     <= last.sum;
        out_err_r     <= 1'b0;
      end else begin
        out_index_a_r <= last.err ? '0 : last.ia;
        out_index_b_r <= last.err ? '0 : last.ib;
        out_sum_r     <= '0;
        out_err_r     <= last.err;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_index_a     = out_index_a_r;
  assign out_index_b     = out_index_b_r;
  assign out_sum_value   = out_sum_r;
  assign out_shape_error = out_err_r;

endmodule

FILE: tb/bqa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqa_checker
// Watches the input, output and register write channels of the broadcast
// quantized add unit, predicts every result beat and compares it field by field.
// ----------------------------------------------------------------------------
module bqa_checker import bqa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_func,
  input  logic [31:0]        in_flat_index,
  input  logic signed [7:0]  in_value_a,
  input  logic signed [7:0]  in_value_b,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [31:0]        out_index_a,
  input  logic [31:0]        out_index_b,
  input  logic signed [7:0]  out_sum_value,
  input  logic               out_shape_error,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  output int                 fail_count,
  output int                 pending,
  output int                 results_seen
);

  typedef struct {
    logic [31:0]       index_a;
    logic [31:0]       index_b;
    logic signed [7:0] sum_value;
    logic              shape_error;
  } add_result_t;

  bqa_cfg_t    regs;
  add_result_t expected_q[$];

  assign pending = expected_q.size();

  function automatic longint floor_q15(longint t);
    return t >>> Q_SHIFT;
  endfunction

  function automatic add_result_t predict_result(logic func, logic [31:0] flat,
                                                 logic signed [7:0] va,
                                                 logic signed [7:0] vb);
    add_result_t r;
    longint unsigned rem, sa, sb, ia, ib, da, db, dout, digit;
    longint corr, s;
    r = '{32'd0, 32'd0, 8'sd0, 1'b0};
    if (!func) begin
      rem = flat;
      sa = 1;
      sb = 1;
      ia = 0;
      ib = 0;
      for (int k = 0; k < NUM_DIMS; k++) begin
        da = regs.shape_a[16*k +: 16];
        db = regs.shape_b[16*k +: 16];
        if (da == 0 || db == 0 || !(da == db || da == 1 || db == 1)) r.shape_error = 1'b1;
      end
      if (!r.shape_error) begin
        for (int k = 0; k < NUM_DIMS; k++) begin
          da = regs.shape_a[16*k +: 16];
          db = regs.shape_b[16*k +: 16];
          dout = (da > db) ? da : db;
          digit = rem % dout;
          rem = rem / dout;
          if (da != 1) ia += digit * sa;
          if (db != 1) ib += digit * sb;
          sa *= da;
          sb *= db;
        end
        r.index_a = ia[31:0];
        r.index_b = ib[31:0];
      end
    end else begin
      corr = floor_q15(longint'(regs.zp_a) * longint'(regs.scale_a)
                       + longint'(regs.zp_b) * longint'(regs.scale_b) + 16384)
             - longint'(regs.zp_out);
      s = floor_q15(longint'(va) * longint'(regs.scale_a) + 16384)
        + floor_q15(longint'(vb) * longint'(regs.scale_b) + 16384) - corr;
      if (regs.relu && s < 0) s = 0;
      if (s > 127) s = 127;
      if (s < -128) s = -128;
      r.sum_value = s[7:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    add_result_t e;
    if (!rst_n) begin
      regs.shape_a <= 64'h0001_0001_0001_0001;
      regs.shape_b <= 64'h0001_0001_0001_0001;
      regs.zp_a    <= '0;
      regs.zp_b    <= '0;
      regs.zp_out  <= '0;
      regs.scale_a <= 24'd32768;
      regs.scale_b <= 24'd32768;
      regs.relu    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (bqa_reg_t'(cfg_index))
          REG_SHAPE_A: regs.shape_a <= cfg_data;
          REG_SHAPE_B: regs.shape_b <= cfg_data;
          REG_ZP_A:    regs.zp_a    <= cfg_data[7:0];
          REG_ZP_B:    regs.zp_b    <= cfg_data[7:0];
          REG_ZP_OUT:  regs.zp_out  <= cfg_data[7:0];
          REG_SCALE_A: regs.scale_a <= cfg_data[23:0];
          REG_SCALE_B: regs.scale_b <= cfg_data[23:0];
          REG_RELU:    regs.relu    <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        expected_q.push_back(predict_result(in_func, in_flat_index, in_value_a, in_value_b));
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected beat", 0, 0);
        end else begin
          e = expected_q.pop_front();
          if (out_index_a !== e.index_a) report_mismatch("index_a", out_index_a, e.index_a);
          if (out_index_b !== e.index_b) report_mismatch("index_b", out_index_b, e.index_b);
          if (out_sum_value !== e.sum_value)
            report_mismatch("sum_value", out_sum_value, e.sum_value);
          if (out_shape_error !== e.shape_error)
            report_mismatch("shape_error", out_shape_error, e.shape_error);
        end
      end
    end
  end

  initial begin
    fail_count = 0;
    results_seen = 0;
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives index and add beats through the broadcast quantized add unit under
// several register settings and random back pressure; the checker judges.
// ----------------------------------------------------------------------------
module testbench import bqa_pkg::*;;

  localparam int LATENCY   = 135;
  localparam int IDLE_STOP = 20000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_func = 1'b0;
  logic [31:0]       in_flat_index = '0;
  logic signed [7:0] in_value_a = '0;
  logic signed [7:0] in_value_b = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [31:0]       out_index_a;
  logic [31:0]       out_index_b;
  logic signed [7:0] out_sum_value;
  logic              out_shape_error;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [2:0]        cfg_index = '0;
  logic [63:0]       cfg_data = '0;
  int                fail_count, pending, results_seen;
  int                send_idle_pct, recv_stall_pct;
  int                quiet_cycles;
  int                beats_sent, cfg_writes;

  always #10 clk = ~clk;

  broadcast_quantized_int8_add_unit u_top (.*);

  bqa_checker u_chk (.*);

  // receiver back pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_STOP) begin
      $display("watchdog: no beat for %0d cycles", IDLE_STOP);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(bqa_reg_t idx, logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  task automatic wait_drained();
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic send_beat(logic func, logic [31:0] flat, logic [7:0] va, logic [7:0] vb);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_func       <= func;
    in_flat_index <= flat;
    in_value_a    <= va;
    in_value_b    <= vb;
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  function automatic logic [63:0] pack_shape(int d3, int d2, int d1, int d0);
    return {d3[15:0], d2[15:0], d1[15:0], d0[15:0]};
  endfunction

  function automatic int rand_shape_dim();
    int d;
    case ($urandom_range(3))
      0: d = 1;
      1: d = $urandom_range(2, 5);
      2: d = $urandom_range(6, 40);
      default: d = $urandom_range(65535);
    endcase
    return d;
  endfunction

  // one register setting; broadcast-compatible shapes most of the time
  task automatic random_setting(int phase);
    logic [63:0] sa, sb;
    int da, db;
    for (int k = 0; k < 4; k++) begin
      da = rand_shape_dim();
      db = ($urandom_range(99) < 45) ? da : (($urandom_range(1)) ? 1 : rand_shape_dim());
      if ($urandom_range(1)) begin
        sa[16*k +: 16] = da[15:0];
        sb[16*k +: 16] = db[15:0];
      end else begin
        sa[16*k +: 16] = db[15:0];
        sb[16*k +: 16] = da[15:0];
      end
    end
    if (phase % 5 == 4) sa[16*$urandom_range(3) +: 16] = 16'd0;
    write_reg(REG_SHAPE_A, sa);
    write_reg(REG_SHAPE_B, sb);
    write_reg(REG_ZP_A, {$urandom, $urandom});
    write_reg(REG_ZP_B, {$urandom, $urandom});
    write_reg(REG_ZP_OUT, {$urandom, $urandom});
    write_reg(REG_SCALE_A, (phase % 3 == 0) ? {$urandom, $urandom} : 64'($urandom_range(65536)));
    write_reg(REG_SCALE_B, (phase % 3 == 1) ? {$urandom, $urandom} : 64'($urandom_range(65536)));
    write_reg(REG_RELU, {$urandom, $urandom});
  endtask

  task automatic random_beats(int count);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(3))
        0: send_beat(1'b0, $urandom, 8'($urandom), 8'($urandom));
        1: send_beat(1'b0, $urandom_range(5000), 8'($urandom), 8'($urandom));
        default: send_beat(1'b1, $urandom, 8'($urandom), 8'($urandom));
      endcase
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    quiet_cycles   = 0;
    beats_sent     = 0;
    cfg_writes     = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, then extremes
    send_beat(1'b0, 32'd0, 8'sd0, 8'sd0);
    send_beat(1'b0, 32'hFFFF_FFFF, 8'sd0, 8'sd0);
    send_beat(1'b1, 32'd0, 8'sd127, 8'sd127);
    send_beat(1'b1, 32'd0, -8'sd128, -8'sd128);
    send_beat(1'b1, 32'hFFFF_FFFF, -8'sd1, 8'sd1);
    in_valid <= 1'b0;
    wait_drained();

    // broadcast shapes with index wrap past the end
    write_reg(REG_SHAPE_A, pack_shape(1, 3, 1, 4));
    write_reg(REG_SHAPE_B, pack_shape(2, 1, 5, 4));
    write_reg(REG_ZP_A, 64'h80);
    write_reg(REG_ZP_B, 64'h7F);
    write_reg(REG_ZP_OUT, 64'h80);
    write_reg(REG_SCALE_A, 64'hFF_FFFF);
    write_reg(REG_SCALE_B, 64'd0);
    write_reg(REG_RELU, 64'd1);
    for (int i = 0; i < 6; i++) send_beat(1'b0, i * 23, 8'sd0, 8'sd0);
    send_beat(1'b0, 32'd120, 8'sd0, 8'sd0);
    send_beat(1'b0, 32'hFFFF_FFFF, 8'sd0, 8'sd0);
    send_beat(1'b1, 32'd0, -8'sd128, 8'sd127);
    send_beat(1'b1, 32'd0, 8'sd127, -8'sd128);
    send_beat(1'b1, 32'd0, -8'sd1, 8'sd0);
    in_valid <= 1'b0;
    wait_drained();

    // zero dimension, incompatible dimension, largest dims
    write_reg(REG_SHAPE_A, pack_shape(1, 0, 1, 1));
    send_beat(1'b0, 32'd5, 8'sd0, 8'sd0);
    in_valid <= 1'b0;
    wait_drained();
    write_reg(REG_SHAPE_A, pack_shape(1, 1, 3, 2));
    write_reg(REG_SHAPE_B, pack_shape(1, 1, 4, 2));
    send_beat(1'b0, 32'd5, 8'sd0, 8'sd0);
    in_valid <= 1'b0;
    wait_drained();
    write_reg(REG_SHAPE_A, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_SHAPE_B, pack_shape(1, 65535, 1, 65535));
    send_beat(1'b0, 32'hFFFF_FFFF, 8'sd0, 8'sd0);
    send_beat(1'b0, 32'h1234_5678, 8'sd0, 8'sd0);
    in_valid <= 1'b0;
    wait_drained();

    // random phases under three idling regimes
    for (int phase = 0; phase < 12; phase++) begin
      send_idle_pct  = (phase < 4) ? 20 : (phase < 8) ? 52 : 0;
      recv_stall_pct = (phase < 4) ? 52 : (phase < 8) ? 20 : 0;
      random_setting(phase);
      random_beats(66);
      wait_drained();
    end

    $display("covered %0d input beats and %0d result beats over %0d register writes",
             beats_sent, results_seen, cfg_writes);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
src/bqa_pkg.sv
src/bqa_div_cell.sv
src/bqa_acc_cell.sv
src/bqa_front.sv
src/broadcast_quantized_int8_add_unit.sv
tb/bqa_checker.sv
tb/testbench.sv
